/* rtl/wtda_pkg.sv */
package wtda_pkg;

    localparam int COUNTER_BITS_DEFAULT = 8;

    localparam int STEP_BITS  = 9;
    localparam int TICK_BITS  = 32;
    localparam int DIST_BITS  = 48;
    localparam int SCALE_BITS = 32;
    localparam int THR_BITS   = 8;

    // distance sum with guard bits for saturation
    localparam int DIST_SUM_BITS = DIST_BITS + 2;

    localparam int M_FIELD_BITS  = STEP_BITS + 2 * TICK_BITS + 2 * DIST_BITS;
    localparam int M_TDATA_BITS  = ((M_FIELD_BITS + 7) / 8) * 8;

    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_ADDR_BITS = 3;

    typedef enum logic {
        REG_WRAP_THRESHOLD = 1'b0,
        REG_CM_PER_TICK    = 1'b1
    } cfg_reg_t;

    localparam logic [THR_BITS-1:0]   WRAP_THRESHOLD_RESET = 8'd60;
    localparam logic [SCALE_BITS-1:0] CM_PER_TICK_RESET    = 32'd5346;

endpackage

/* rtl/wtda_step.sv */
module wtda_step #(
    parameter int COUNTER_BITS = wtda_pkg::COUNTER_BITS_DEFAULT,
    localparam int PROD_BITS = COUNTER_BITS + wtda_pkg::SCALE_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               advance,
    input  logic [COUNTER_BITS-1:0]            counter_value,
    input  logic [wtda_pkg::THR_BITS-1:0]      wrap_threshold,
    input  logic [wtda_pkg::SCALE_BITS-1:0]    cm_per_tick_q16,
    output logic [COUNTER_BITS:0]              delta_reg,
    output logic [COUNTER_BITS-1:0]            mag_reg,
    output logic [PROD_BITS-1:0]               prod_reg
);
    import wtda_pkg::*;

    localparam int N  = COUNTER_BITS;
    localparam int CW = (N > THR_BITS) ? N : THR_BITS;
    localparam logic [N+1:0] CNT_MOD = (N + 2)'(1) << N;

    logic              have_previous_reg;
    logic [N-1:0]      previous_count_reg;

    logic [N+1:0]      diff;
    logic [N+1:0]      diff_abs;
    logic [N+1:0]      diff_fix;
    logic [THR_BITS-1:0] thr;
    logic              wrapped;
    logic [N:0]        delta_next;
    logic [N:0]        delta_abs;
    logic [N-1:0]      mag_next;
    logic [PROD_BITS-1:0] prod_next;

    always_comb begin
        thr      = (wrap_threshold == '0) ? THR_BITS'(1) : wrap_threshold;
        diff     = {2'b00, previous_count_reg} - {2'b00, counter_value};
        diff_abs = diff[N+1] ? (~diff + (N + 2)'(1)) : diff;
        wrapped  = CW'(diff_abs[N-1:0]) >= CW'(thr);
        if (!wrapped) begin
            diff_fix = diff;
        end else if (previous_count_reg > counter_value) begin
            diff_fix = diff - CNT_MOD;
        end else begin
            diff_fix = diff + CNT_MOD;
        end
        delta_next = have_previous_reg ? diff_fix[N:0] : '0;
        delta_abs  = delta_next[N] ? (~delta_next + (N + 1)'(1)) : delta_next;
        mag_next   = delta_abs[N-1:0];
        prod_next  = PROD_BITS'(mag_next) * PROD_BITS'(cm_per_tick_q16);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_previous_reg  <= 1'b0;
            previous_count_reg <= '0;
        end else if (advance) begin
            have_previous_reg  <= 1'b1;
            previous_count_reg <= counter_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            delta_reg <= delta_next;
            mag_reg   <= mag_next;
            prod_reg  <= prod_next;
        end
    end

endmodule

/* rtl/wtda_accum.sv */
module wtda_accum #(
    parameter int COUNTER_BITS = wtda_pkg::COUNTER_BITS_DEFAULT,
    localparam int PROD_BITS = COUNTER_BITS + wtda_pkg::SCALE_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              advance,
    input  logic [COUNTER_BITS:0]             delta,
    input  logic [COUNTER_BITS-1:0]           mag,
    input  logic [PROD_BITS-1:0]              prod,
    output logic [wtda_pkg::STEP_BITS-1:0]    step_delta_reg,
    output logic [wtda_pkg::TICK_BITS-1:0]    tick_sum_reg,
    output logic [wtda_pkg::TICK_BITS-1:0]    tick_abs_sum_reg,
    output logic [wtda_pkg::DIST_BITS-1:0]    dist_sum_reg,
    output logic [wtda_pkg::DIST_BITS-1:0]    dist_abs_sum_reg
);
    import wtda_pkg::*;

    localparam int N  = COUNTER_BITS;
    localparam int EW = (N + 1 > STEP_BITS) ? N + 1 : STEP_BITS;
    localparam logic [TICK_BITS-1:0] S32_MAX = {1'b0, {(TICK_BITS-1){1'b1}}};
    localparam logic [TICK_BITS-1:0] S32_MIN = {1'b1, {(TICK_BITS-1){1'b0}}};
    localparam logic [DIST_BITS-1:0] S48_MAX = {1'b0, {(DIST_BITS-1){1'b1}}};
    localparam logic [DIST_BITS-1:0] S48_MIN = {1'b1, {(DIST_BITS-1){1'b0}}};

    logic                      neg;
    logic [EW-1:0]             delta_ext;
    logic [TICK_BITS:0]        tick_add;
    logic [TICK_BITS:0]        tick_abs_add;
    logic [DIST_SUM_BITS-1:0]  prod_ext;
    logic [DIST_SUM_BITS-1:0]  prod_term;
    logic [DIST_SUM_BITS-1:0]  dist_add;
    logic [DIST_BITS:0]        dist_abs_add;

    logic [STEP_BITS-1:0]      step_delta_next;
    logic [TICK_BITS-1:0]      tick_sum_next;
    logic [TICK_BITS-1:0]      tick_abs_sum_next;
    logic [DIST_BITS-1:0]      dist_sum_next;
    logic [DIST_BITS-1:0]      dist_abs_sum_next;

    always_comb begin
        neg       = delta[N];
        delta_ext = {{(EW-N-1){delta[N]}}, delta};
        step_delta_next = delta_ext[STEP_BITS-1:0];

        tick_add = {tick_sum_reg[TICK_BITS-1], tick_sum_reg}
                 + {{(TICK_BITS-N){delta[N]}}, delta};
        if (tick_add[TICK_BITS] != tick_add[TICK_BITS-1]) begin
            tick_sum_next = tick_add[TICK_BITS] ? S32_MIN : S32_MAX;
        end else begin
            tick_sum_next = tick_add[TICK_BITS-1:0];
        end

        tick_abs_add = {1'b0, tick_abs_sum_reg} + (TICK_BITS + 1)'(mag);
        tick_abs_sum_next = tick_abs_add[TICK_BITS] ? '1 : tick_abs_add[TICK_BITS-1:0];

        // conditional negate folded into the add
        prod_ext  = DIST_SUM_BITS'(prod);
        prod_term = neg ? ~prod_ext : prod_ext;
        dist_add  = {{(DIST_SUM_BITS-DIST_BITS){dist_sum_reg[DIST_BITS-1]}}, dist_sum_reg}
                  + prod_term + DIST_SUM_BITS'(neg);
        if (dist_add[DIST_SUM_BITS-1:DIST_BITS-1] != '0
            && dist_add[DIST_SUM_BITS-1:DIST_BITS-1] != '1) begin
            dist_sum_next = dist_add[DIST_SUM_BITS-1] ? S48_MIN : S48_MAX;
        end else begin
            dist_sum_next = dist_add[DIST_BITS-1:0];
        end

        dist_abs_add = {1'b0, dist_abs_sum_reg} + (DIST_BITS + 1)'(prod);
        dist_abs_sum_next = dist_abs_add[DIST_BITS] ? '1 : dist_abs_add[DIST_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_sum_reg     <= '0;
            tick_abs_sum_reg <= '0;
            dist_sum_reg     <= '0;
            dist_abs_sum_reg <= '0;
        end else if (advance) begin
            tick_sum_reg     <= tick_sum_next;
            tick_abs_sum_reg <= tick_abs_sum_next;
            dist_sum_reg     <= dist_sum_next;
            dist_abs_sum_reg <= dist_abs_sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            step_delta_reg <= step_delta_next;
        end
    end

endmodule

/* rtl/wrapping_tick_distance_accumulator_core.sv */
// Wheel tick odometer. Each item on the s_ channel is one reading of a
// free-running wheel tick counter; each item on the m_ channel is the
// wrap-corrected delta of that reading and the running totals after it.
// The first reading after reset seeds the previous value and yields delta 0.
// Registers over APB: 0x0 wrap threshold (8 bits), 0x4 cm per tick (Q16.16).
// Write them only while no item is in flight.
// Throughput: one item per cycle while m_tready stays high; the path
// is input register, delta and multiplier stage, then the saturating
// accumulator stage that also holds the result and drives m_tvalid.
// When m_tready is low the result holds and the two earlier stages
// still fill, so up to three items are held before s_tready drops.
// Reset clears the pipeline, the previous reading and all totals, and
// restores the register defaults.
module wrapping_tick_distance_accumulator_core #(
    parameter int COUNTER_BITS = wtda_pkg::COUNTER_BITS_DEFAULT,
    localparam int S_TDATA_BITS = ((COUNTER_BITS + 7) / 8) * 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [COUNTER_BITS-1:0] counter_value, rest zero
    input  logic [S_TDATA_BITS-1:0]              s_tdata,

    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [8:0] step_delta, [40:9] total_ticks, [72:41] total_abs_ticks,
    // [120:73] distance_cm_q16, [168:121] abs_distance_cm_q16, rest zero
    output logic [wtda_pkg::M_TDATA_BITS-1:0]    m_tdata,

    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [wtda_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [wtda_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [wtda_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                 pready
);
    import wtda_pkg::*;

    localparam int N = COUNTER_BITS;
    localparam int PROD_BITS = N + SCALE_BITS;

    logic [THR_BITS-1:0]   wrap_threshold_reg;
    logic [SCALE_BITS-1:0] cm_per_tick_reg;
    cfg_reg_t              cfg_sel;
    logic                  cfg_write;

    logic                  in_valid_reg;
    logic                  mid_valid_reg;
    logic                  out_valid_reg;
    logic [N-1:0]          counter_reg;

    logic                  out_free;
    logic                  mid_advance;
    logic                  mid_free;
    logic                  in_advance;
    logic                  s_accept;

    logic [N:0]            delta;
    logic [N-1:0]          mag;
    logic [PROD_BITS-1:0]  prod;

    logic [STEP_BITS-1:0]  step_delta;
    logic [TICK_BITS-1:0]  total_ticks;
    logic [TICK_BITS-1:0]  total_abs_ticks;
    logic [DIST_BITS-1:0]  distance_cm_q16;
    logic [DIST_BITS-1:0]  abs_distance_cm_q16;

    assign pready    = 1'b1;
    assign cfg_sel   = cfg_reg_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wrap_threshold_reg <= WRAP_THRESHOLD_RESET;
            cm_per_tick_reg    <= CM_PER_TICK_RESET;
        end else if (cfg_write) begin
            unique case (cfg_sel)
                REG_WRAP_THRESHOLD: wrap_threshold_reg <= pwdata[THR_BITS-1:0];
                REG_CM_PER_TICK:    cm_per_tick_reg    <= pwdata[SCALE_BITS-1:0];
                default:            ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            REG_WRAP_THRESHOLD: prdata = CFG_DATA_BITS'(wrap_threshold_reg);
            REG_CM_PER_TICK:    prdata = CFG_DATA_BITS'(cm_per_tick_reg);
            default:            prdata = '0;
        endcase
    end

    always_comb begin
        out_free    = !out_valid_reg || m_tready;
        mid_advance = mid_valid_reg && out_free;
        mid_free    = !mid_valid_reg || mid_advance;
        in_advance  = in_valid_reg && mid_free;
        s_tready    = !in_valid_reg || in_advance;
        s_accept    = s_tvalid && s_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (mid_free) begin
                mid_valid_reg <= in_valid_reg;
            end
            if (out_free) begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            counter_reg <= s_tdata[N-1:0];
        end
    end

    wtda_step #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_step (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .advance         (in_advance),
        .counter_value   (counter_reg),
        .wrap_threshold  (wrap_threshold_reg),
        .cm_per_tick_q16 (cm_per_tick_reg),
        .delta_reg       (delta),
        .mag_reg         (mag),
        .prod_reg        (prod)
    );

    wtda_accum #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_accum (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .advance          (mid_advance),
        .delta            (delta),
        .mag              (mag),
        .prod             (prod),
        .step_delta_reg   (step_delta),
        .tick_sum_reg     (total_ticks),
        .tick_abs_sum_reg (total_abs_ticks),
        .dist_sum_reg     (distance_cm_q16),
        .dist_abs_sum_reg (abs_distance_cm_q16)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_BITS - M_FIELD_BITS){1'b0}},
                       abs_distance_cm_q16, distance_cm_q16,
                       total_abs_ticks, total_ticks, step_delta};

endmodule
